// ===== design/npcs_pkg.sv =====
// Shared constants and types for the nearest palette color search.
// No dependencies; npcs_dist and the top level import this package.
package npcs_pkg;

    // Fixed widths of the word fields
    localparam int FIELD_W = 8;
    localparam int INDEX_W = 7;

    // Operation codes carried by an input word
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Scan control that travels from the ring sequencer to the distance unit
    typedef struct packed {
        logic feed;   // an entry from the head of the ring is presented
        logic first;  // presented entry is palette slot zero
        logic last;   // presented entry is the final palette slot
    } t_scan_ctl;

endpackage

// ===== design/npcs_cell.sv =====
// One cell of the palette ring: holds a valid mark and one RGB color.
// Loads from the write port or takes its neighbor's entry on a shift.
// No package dependencies.
module npcs_cell #(
    parameter int COMPONENT_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_load,
    input  logic                        i_load_valid,
    input  logic [3*COMPONENT_BITS-1:0] i_load_rgb,
    input  logic                        i_next_valid,
    input  logic [3*COMPONENT_BITS-1:0] i_next_rgb,
    output logic                        o_valid,
    output logic [3*COMPONENT_BITS-1:0] o_rgb
);

    logic                        r_valid;
    logic                        n_valid;
    logic [3*COMPONENT_BITS-1:0] r_rgb;
    logic [3*COMPONENT_BITS-1:0] n_rgb;

    // Load wins over shift; otherwise hold
    always_comb begin
        n_valid = r_valid;
        n_rgb   = r_rgb;
        if (i_load) begin
            n_valid = i_load_valid;
            n_rgb   = i_load_rgb;
        end else if (i_shift) begin
            n_valid = i_next_valid;
            n_rgb   = i_next_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= n_rgb;
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

// ===== design/npcs_dist.sv =====
// Distance and running-minimum unit fed from the head of the palette ring.
// Four stages: abs difference, square, sum, compare and update.
// Depends on npcs_pkg (t_scan_ctl).
module npcs_dist #(
    parameter int COMPONENT_BITS = 8,
    parameter int IDX_W          = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  npcs_pkg::t_scan_ctl         i_ctl,
    input  logic                        i_entry_valid,
    input  logic [3*COMPONENT_BITS-1:0] i_entry_rgb,
    input  logic [3*COMPONENT_BITS-1:0] i_query_rgb,
    input  logic [IDX_W-1:0]            i_index,
    output logic                        o_done,
    output logic [IDX_W-1:0]            o_index
);
    import npcs_pkg::*;

    localparam int CB    = COMPONENT_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = 2 * CB + 2;

    // Stage 1: absolute differences
    t_scan_ctl        r1_ctl;
    logic             r1_valid;
    logic [IDX_W-1:0] r1_idx;
    logic [CB-1:0]    r1_diff [3];
    logic [CB-1:0]    n1_diff [3];

    // Stage 2: squares
    t_scan_ctl        r2_ctl;
    logic             r2_valid;
    logic [IDX_W-1:0] r2_idx;
    logic [SQ_W-1:0]  r2_sq [3];
    logic [SQ_W-1:0]  n2_sq [3];

    // Stage 3: distance
    t_scan_ctl        r3_ctl;
    logic             r3_valid;
    logic [IDX_W-1:0] r3_idx;
    logic [SUM_W-1:0] r3_sum;

    // Stage 4: running best
    logic             r_found;
    logic [SUM_W-1:0] r_best;
    logic [IDX_W-1:0] r_best_idx;
    logic             r_done;
    logic             n_found;
    logic [SUM_W-1:0] n_best;
    logic [IDX_W-1:0] n_best_idx;
    logic             base_found;
    logic [SUM_W-1:0] base_best;
    logic [IDX_W-1:0] base_idx;
    logic             take;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (i_entry_rgb[c*CB +: CB] >= i_query_rgb[c*CB +: CB]) begin
                n1_diff[c] = i_entry_rgb[c*CB +: CB] - i_query_rgb[c*CB +: CB];
            end else begin
                n1_diff[c] = i_query_rgb[c*CB +: CB] - i_entry_rgb[c*CB +: CB];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n2_sq[c] = SQ_W'(r1_diff[c]) * SQ_W'(r1_diff[c]);
        end
    end

    // Restart the minimum on slot zero; strict less-than keeps the lowest index on ties
    always_comb begin
        base_found = r3_ctl.first ? 1'b0 : r_found;
        base_best  = r3_ctl.first ? '0 : r_best;
        base_idx   = r3_ctl.first ? '0 : r_best_idx;
        take       = r3_valid && (!base_found || (r3_sum < base_best));
        n_found    = r_found;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        if (r3_ctl.feed) begin
            n_found    = base_found | take;
            n_best     = take ? r3_sum : base_best;
            n_best_idx = take ? r3_idx : base_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl  <= '0;
            r2_ctl  <= '0;
            r3_ctl  <= '0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r1_ctl  <= i_ctl;
            r2_ctl  <= r1_ctl;
            r3_ctl  <= r2_ctl;
            r_found <= n_found;
            r_done  <= r3_ctl.feed & r3_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_valid   <= i_entry_valid;
        r1_idx     <= i_index;
        r1_diff    <= n1_diff;
        r2_valid   <= r1_valid;
        r2_idx     <= r1_idx;
        r2_sq      <= n2_sq;
        r3_valid   <= r2_valid;
        r3_idx     <= r2_idx;
        r3_sum     <= SUM_W'(r2_sq[0]) + SUM_W'(r2_sq[1]) + SUM_W'(r2_sq[2]);
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
    end

    assign o_done  = r_done;
    assign o_index = r_best_idx;

endmodule

// ===== design/nearest_palette_color_search.sv =====
// Top level of the nearest palette color search: palette ring, scan sequencer,
// distance unit and output register.
// Depends on npcs_pkg, npcs_cell and npcs_dist.
//
//  Channel  | Direction | Handshake          | Word
//  ---------+-----------+--------------------+------------------------------------------
//  input    | in        | i_valid / o_stall  | operation, entry_index, entry_valid, RGB
//  output   | out       | o_valid / i_stall  | color_index (one per query word)
//
//  A write word loads the addressed cell at the accepting edge.
//  A query word rotates the palette ring once past the distance unit, one entry
//  per cycle, then four pipeline stages drain into the output register.
//  Reset (synchronous, active low) clears every valid mark at once; no sweep.
//  o_stall is high while a query is in flight, and for query words while a result waits;
//  write words are still taken while a result is held under i_stall.
module nearest_palette_color_search #(
    parameter int PALETTE_SIZE   = 128,
    parameter int COMPONENT_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic [npcs_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic                           i_entry_valid,
    input  logic [npcs_pkg::FIELD_W-1:0]   i_red,
    input  logic [npcs_pkg::FIELD_W-1:0]   i_green,
    input  logic [npcs_pkg::FIELD_W-1:0]   i_blue,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [npcs_pkg::INDEX_W-1:0]   o_color_index
);
    import npcs_pkg::*;

    localparam int CB    = COMPONENT_BITS;
    localparam int IDX_W = $clog2(PALETTE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_SIZE - 1);

    logic              in_accept;
    logic              wr_accept;
    logic              qry_accept;
    logic [3*CB-1:0]   load_rgb;

    // Ring of cells; the head is cell zero and each cell takes from its upper neighbor
    logic              c_valid [PALETTE_SIZE];
    logic [3*CB-1:0]   c_rgb   [PALETTE_SIZE];

    // Scan sequencer
    logic              r_scanning;
    logic              n_scanning;
    logic [IDX_W-1:0]  r_scan_idx;
    logic [IDX_W-1:0]  n_scan_idx;
    logic              r_busy;
    logic              n_busy;
    logic [3*CB-1:0]   r_query_rgb;
    t_scan_ctl         scan_ctl;

    logic              dist_done;
    logic [IDX_W-1:0]  dist_index;

    // Output register
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [INDEX_W-1:0]   r_out_index;
    logic [INDEX_W-1:0]   n_out_index;

    assign in_accept  = i_valid & ~o_stall;
    assign wr_accept  = in_accept && (i_operation == OP_WRITE)
                        && (32'(i_entry_index) < 32'(PALETTE_SIZE));
    assign qry_accept = in_accept && (i_operation == OP_QUERY);

    // Keep only the low COMPONENT_BITS of each component; red sits lowest
    assign load_rgb = {CB'(i_blue), CB'(i_green), CB'(i_red)};

    // Stall while a query is in flight; hold off a new query while the last result waits
    assign o_stall = r_busy | (r_out_valid & (i_operation == OP_QUERY));

    for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
        localparam int NEXT = (k + 1) % PALETTE_SIZE;
        npcs_cell #(
            .COMPONENT_BITS (CB)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (r_scanning),
            .i_load       (wr_accept && (32'(i_entry_index) == 32'(k))),
            .i_load_valid (i_entry_valid),
            .i_load_rgb   (load_rgb),
            .i_next_valid (c_valid[NEXT]),
            .i_next_rgb   (c_rgb[NEXT]),
            .o_valid      (c_valid[k]),
            .o_rgb        (c_rgb[k])
        );
    end

    // The ring makes one full turn per query, so it ends where it started and
    // slot numbers line up with cell numbers again whenever the block is idle
    always_comb begin
        scan_ctl.feed  = r_scanning;
        scan_ctl.first = r_scanning && (r_scan_idx == '0);
        scan_ctl.last  = r_scanning && (r_scan_idx == LAST_IDX);
    end

    always_comb begin
        n_scanning = r_scanning;
        n_scan_idx = r_scan_idx;
        n_busy     = r_busy;
        if (qry_accept) begin
            n_scanning = 1'b1;
            n_scan_idx = '0;
            n_busy     = 1'b1;
        end else if (r_scanning) begin
            // advance one slot; drop out of the scan after the last one
            n_scan_idx = r_scan_idx + 1'b1;
            if (r_scan_idx == LAST_IDX) begin
                n_scanning = 1'b0;
            end
        end
        if (dist_done) begin
            n_busy = 1'b0;
        end
    end

    npcs_dist #(
        .COMPONENT_BITS (CB),
        .IDX_W          (IDX_W)
    ) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_entry_valid (c_valid[0]),
        .i_entry_rgb   (c_rgb[0]),
        .i_query_rgb   (r_query_rgb),
        .i_index       (r_scan_idx),
        .o_done        (dist_done),
        .o_index       (dist_index)
    );

    // Capture the result; hold it until the downstream side takes the word
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_index = r_out_index;
        if (dist_done) begin
            n_out_valid = 1'b1;
            n_out_index = INDEX_W'(dist_index);
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning  <= 1'b0;
            r_scan_idx  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_scanning  <= n_scanning;
            r_scan_idx  <= n_scan_idx;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_accept) begin
            r_query_rgb <= load_rgb;
        end
        r_out_index <= n_out_index;
    end

    assign o_valid       = r_out_valid;
    assign o_color_index = r_out_index;

`ifndef SYNTHESIS
    a_out_not_scanning : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !r_scanning)
        else $error("result held while the ring is scanning");

    a_done_while_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_done |-> r_busy)
        else $error("distance unit finished with no query in flight");

    a_scan_from_query : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_scanning) |-> $past(in_accept && (i_operation == OP_QUERY)))
        else $error("scan started without an accepted query word");
`endif

endmodule
